// ===== src/plt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// plt_pkg: predecessor link table shared types
// Table depth, opcodes, register indexes, channel words and the scan token
// that walks the row of table cells.
// ----------------------------------------------------------------------------
package plt_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam logic [7:0] MASTER_HOP  = 8'd1;
  localparam logic [7:0] MASTER_ID   = 8'd0;
  localparam logic [7:0] MASTER_RSSI = 8'd5;
  localparam logic [7:0] ROOT_HOP_LT = 8'd2;   // hops below this count as rooted

  typedef enum logic [1:0] {
    OP_HEARD  = 2'd0,
    OP_MISSED = 2'd1,
    OP_HOP    = 2'd2,
    OP_QUERY  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CFG_MIN_RSSI   = 2'd0,
    CFG_MAX_MISSED = 2'd1,
    CFG_OWN_ID     = 2'd2,
    CFG_LOST_RSSI  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    op_e         opcode;
    logic [7:0]  sender_id;
    logic [7:0]  sender_hop;
    logic [7:0]  link_rssi;
    logic [7:0]  new_hop;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  best_predecessor;
    logic        has_predecessor;
    logic [4:0]  entry_count;
    logic        insert_dropped;
  } out_word_t;

  typedef struct packed {
    logic [7:0]  min_rssi;
    logic [7:0]  max_missed;
    logic [7:0]  own_id;
    logic [7:0]  lost_rssi;
  } cfg_t;

  typedef struct packed {
    logic        valid;
    logic [7:0]  node;
    logic [7:0]  rssi;
    logic [7:0]  missed;
  } slot_t;

  // Token carried down the cell row, one cell per cycle.
  typedef struct packed {
    logic             valid;
    op_e              op;
    logic [7:0]       sender;
    logic [7:0]       rssi;
    logic             act;        // still looking for the sender
    logic             ins;        // append still pending
    logic             master;     // load master into the first cell
    logic             shift;      // compaction under way
    logic [CNT_W-1:0] count;
    logic             have_best;
    logic [7:0]       best_rssi;
    logic [7:0]       best_node;
  } tok_t;

endpackage
`default_nettype wire

// ===== src/predecessor_link_table_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// predecessor_link_table_unit: upstream neighbor table with link aging
// Keeps an ordered table of predecessors and answers each event word with
// the best predecessor, a has-predecessor flag, the entry count and a drop flag.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_word_i) takes one event word:
//   heard, missed round, change hop or query. Output channel (out_valid_o /
//   out_stall_i / out_word_o) returns exactly one result word per event.
//   The table is a row of TABLE_DEPTH cells. An accepted word becomes a scan
//   token that visits one cell per cycle, updating that cell and gathering
//   count and best entry; compaction after a removal rides along with it.
//   The result word is registered from the token leaving the last cell.
//   A new word is taken only after the scan ends, as the token's walk down
//   the cell row holds in_stall_o high; one token is in flight at a time.
//   A finished result waits in the output register; one more result can be
//   parked behind it, so the next word is taken while the receiver stalls.
//   in_stall_o stays high during a scan and while a parked result exists.
//   Reset: table empty, hop zero, registers at their documented defaults.
//   Configuration writes are taken at any edge with cfg_we_i high and are
//   meant to happen while the block is idle.
// ----------------------------------------------------------------------------
module predecessor_link_table_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire plt_pkg::in_word_t  in_word_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output plt_pkg::out_word_t      out_word_o,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_idx_i,
  input  wire logic [7:0]         cfg_data_i
);
  import plt_pkg::*;

  cfg_t       cfg_q;
  logic [7:0] hop_q;
  logic       busy_q;
  logic       out_valid_q, hold_valid_q;
  out_word_t  out_q, hold_q, res;

  tok_t       tok   [TABLE_DEPTH+1];
  slot_t      slots [TABLE_DEPTH];
  slot_t      nbrs  [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] vld;

  logic       in_acc, out_acc;
  logic       hop_ok;
  tok_t       tok_in;
  tok_t       end_tok;

  assign in_stall_o = busy_q | hold_valid_q;
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign out_acc    = out_valid_q & ~out_stall_i;

  // ---- configuration registers ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_rssi   <= 8'hA6;   // -90
      cfg_q.max_missed <= 8'd3;
      cfg_q.own_id     <= 8'd0;
      cfg_q.lost_rssi  <= 8'h80;   // -128
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MIN_RSSI:   cfg_q.min_rssi   <= cfg_data_i;
        CFG_MAX_MISSED: cfg_q.max_missed <= cfg_data_i;
        CFG_OWN_ID:     cfg_q.own_id     <= cfg_data_i;
        CFG_LOST_RSSI:  cfg_q.lost_rssi  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---- token launch: hop check against the hop before this event ----
  assign hop_ok = hop_q > in_word_i.sender_hop;

  always_comb begin
    tok_in        = '0;
    tok_in.valid  = in_acc;
    tok_in.op     = in_word_i.opcode;
    tok_in.sender = in_word_i.sender_id;
    tok_in.rssi   = in_word_i.link_rssi;
    case (in_word_i.opcode)
      OP_HEARD: begin
        tok_in.act = hop_ok;
        tok_in.ins = hop_ok &&
                     ($signed(in_word_i.link_rssi) >= $signed(cfg_q.min_rssi));
      end
      OP_MISSED: tok_in.act    = 1'b1;
      OP_HOP:    tok_in.master = (in_word_i.new_hop == MASTER_HOP);
      default: ;
    endcase
  end

  assign tok[0] = tok_in;

  // ---- cell row ----
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    if (i == TABLE_DEPTH - 1) begin : g_last
      assign nbrs[i] = '0;
    end else begin : g_mid
      assign nbrs[i] = slots[i+1];
    end
    assign vld[i] = slots[i].valid;

    plt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cfg_i  (cfg_q),
      .tok_i  (tok[i]),
      .nbr_i  (nbrs[i]),
      .tok_o  (tok[i+1]),
      .slot_o (slots[i])
    );
  end

  // ---- result from the token leaving the last cell ----
  assign end_tok = tok[TABLE_DEPTH];

  always_comb begin
    res.entry_count     = 5'(end_tok.count);
    res.insert_dropped  = end_tok.ins;
    res.has_predecessor = (hop_q < ROOT_HOP_LT) || end_tok.have_best;
    if (hop_q == MASTER_HOP) begin
      res.best_predecessor = MASTER_ID;
    end else if (end_tok.have_best) begin
      res.best_predecessor = end_tok.best_node;
    end else if (hop_q < ROOT_HOP_LT) begin
      res.best_predecessor = MASTER_ID;
    end else begin
      res.best_predecessor = cfg_q.own_id;
    end
  end

  // ---- control: hop, busy, output register and parked result ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hop_q        <= 8'd0;
      busy_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      hold_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        busy_q <= 1'b1;
        if (in_word_i.opcode == OP_HOP) begin
          hop_q <= in_word_i.new_hop;
        end
      end
      if (end_tok.valid) begin
        busy_q <= 1'b0;
        if (!out_valid_q || out_acc) begin
          out_valid_q <= 1'b1;
        end else begin
          hold_valid_q <= 1'b1;
        end
      end else if (out_acc) begin
        out_valid_q  <= hold_valid_q;
        hold_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (end_tok.valid) begin
      if (!out_valid_q || out_acc) begin
        out_q <= res;
      end else begin
        hold_q <= res;
      end
    end else if (out_acc && hold_valid_q) begin
      out_q <= hold_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // ---- assertions ----
  logic [TABLE_DEPTH:0] tok_vld;
  for (genvar k = 0; k <= TABLE_DEPTH; k++) begin : g_tv
    assign tok_vld[k] = tok[k].valid;
  end

  a_one_token : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_vld))
    else $error("more than one scan token in the cell row");

  a_end_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    end_tok.valid |-> (busy_q && !hold_valid_q))
    else $error("scan finished without a pending slot for its result");

  a_hold_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_valid_q |-> out_valid_q)
    else $error("parked result without a result in the output register");

  a_prefix : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> ((vld & (vld + TABLE_DEPTH'(1))) == '0))
    else $error("valid entries do not form a prefix of the table");

endmodule
`default_nettype wire

// ===== src/plt_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// plt_cell: one table slot
// Holds one entry, applies the passing token to it and hands the token on.
// ----------------------------------------------------------------------------
module plt_cell (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire plt_pkg::cfg_t  cfg_i,
  input  wire plt_pkg::tok_t  tok_i,
  input  wire plt_pkg::slot_t nbr_i,
  output plt_pkg::tok_t       tok_o,
  output plt_pkg::slot_t      slot_o
);
  import plt_pkg::*;

  slot_t      slot_q, slot_d;
  tok_t       tok_q, tok_d;
  logic       hit;
  logic [7:0] miss_inc;

  assign hit      = slot_q.valid && (slot_q.node == tok_i.sender);
  assign miss_inc = (slot_q.missed == 8'hFF) ? slot_q.missed : slot_q.missed + 8'd1;

  always_comb begin
    slot_d = slot_q;
    tok_d  = tok_i;
    if (tok_i.valid) begin
      case (tok_i.op)
        OP_HEARD: begin
          if (tok_i.act && hit) begin
            slot_d.missed = 8'd0;
            slot_d.rssi   = tok_i.rssi;
            tok_d.act     = 1'b0;
            tok_d.ins     = 1'b0;
          end else if (!slot_q.valid && tok_i.ins) begin
            slot_d.valid  = 1'b1;
            slot_d.node   = tok_i.sender;
            slot_d.rssi   = tok_i.rssi;
            slot_d.missed = 8'd0;
            tok_d.ins     = 1'b0;
          end
        end
        OP_MISSED: begin
          if (tok_i.shift) begin
            slot_d = nbr_i;
          end else if (tok_i.act && hit) begin
            tok_d.act = 1'b0;
            if (miss_inc >= cfg_i.max_missed) begin
              slot_d      = nbr_i;
              tok_d.shift = 1'b1;
            end else begin
              slot_d.missed = miss_inc;
              slot_d.rssi   = cfg_i.lost_rssi;
            end
          end
        end
        OP_HOP: begin
          slot_d = '0;
          if (tok_i.master) begin
            slot_d.valid = 1'b1;
            slot_d.node  = MASTER_ID;
            slot_d.rssi  = MASTER_RSSI;
          end
          tok_d.master = 1'b0;
        end
        default: ;
      endcase
      // running count and best choice over the updated entries
      if (slot_d.valid) begin
        tok_d.count = tok_i.count + CNT_W'(1);
        if (!tok_i.have_best || ($signed(slot_d.rssi) > $signed(tok_i.best_rssi))) begin
          tok_d.have_best = 1'b1;
          tok_d.best_rssi = slot_d.rssi;
          tok_d.best_node = slot_d.node;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      tok_q  <= '0;
    end else begin
      slot_q <= slot_d;
      tok_q  <= tok_d;
    end
  end

  assign tok_o  = tok_q;
  assign slot_o = slot_q;

endmodule
`default_nettype wire

// ===== bench/plt_result_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plt_result_check: result checker for the predecessor link table
// Watches the event, result and register ports, keeps its own copy of the
// neighbor table, and compares every result word with the oldest prediction.
// ----------------------------------------------------------------------------
module plt_result_check (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  plt_pkg::in_word_t  in_word_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  plt_pkg::out_word_t out_word_i,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [7:0]         cfg_data_i,
  output int                 fail_count_o,
  output int                 pending_o
);
  import plt_pkg::*;

  // register copies
  logic [7:0] min_rssi, max_missed, own_id, lost_rssi;

  // table copy; entries below pred_len are valid
  logic [7:0] pred_node   [TABLE_DEPTH];
  logic [7:0] pred_rssi   [TABLE_DEPTH];
  logic [7:0] pred_missed [TABLE_DEPTH];
  int         pred_len;
  logic [7:0] hop_now;

  out_word_t  due_results [$];
  int         results_seen;

  function automatic int find_pred(logic [7:0] id);
    for (int i = 0; i < pred_len; i++)
      if (pred_node[i] == id) return i;
    return -1;
  endfunction

  // Applies one event word to the table copy and returns the result word.
  function automatic out_word_t next_result(in_word_t w);
    out_word_t r;
    int        pos;
    int        bi;
    logic      dropped;
    dropped = 1'b0;
    r = '0;
    case (w.opcode)
      OP_HEARD: begin
        // only nodes closer to the master count
        if (hop_now > w.sender_hop) begin
          pos = find_pred(w.sender_id);
          if (pos >= 0) begin
            pred_missed[pos] = 8'h00;
            pred_rssi[pos]   = w.link_rssi;
          end else if ($signed(w.link_rssi) >= $signed(min_rssi)) begin
            if (pred_len < TABLE_DEPTH) begin
              pred_node[pred_len]   = w.sender_id;
              pred_rssi[pred_len]   = w.link_rssi;
              pred_missed[pred_len] = 8'h00;
              pred_len++;
            end else begin
              dropped = 1'b1;
            end
          end
        end
      end
      OP_MISSED: begin
        pos = find_pred(w.sender_id);
        if (pos >= 0) begin
          if (pred_missed[pos] != 8'hFF) pred_missed[pos]++;
          pred_rssi[pos] = lost_rssi;
          if (pred_missed[pos] >= max_missed) begin
            // compact: later entries move up in order
            for (int i = pos; i < pred_len - 1; i++) begin
              pred_node[i]   = pred_node[i + 1];
              pred_rssi[i]   = pred_rssi[i + 1];
              pred_missed[i] = pred_missed[i + 1];
            end
            pred_len--;
          end
        end
      end
      OP_HOP: begin
        hop_now  = w.new_hop;
        pred_len = 0;
        if (w.new_hop == MASTER_HOP) begin
          pred_node[0]   = MASTER_ID;
          pred_rssi[0]   = MASTER_RSSI;
          pred_missed[0] = 8'h00;
          pred_len       = 1;
        end
      end
      default: ;
    endcase

    if (hop_now == MASTER_HOP) begin
      r.best_predecessor = MASTER_ID;
    end else if (pred_len > 0) begin
      bi = 0;
      for (int i = 1; i < pred_len; i++)
        if ($signed(pred_rssi[i]) > $signed(pred_rssi[bi])) bi = i;
      r.best_predecessor = pred_node[bi];
    end else if (hop_now < ROOT_HOP_LT) begin
      r.best_predecessor = 8'h00;
    end else begin
      r.best_predecessor = own_id;
    end
    r.has_predecessor = (hop_now < ROOT_HOP_LT) || (pred_len > 0);
    r.entry_count     = 5'(pred_len);
    r.insert_dropped  = dropped;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_word_t want;
    if (!rst_ni) begin
      min_rssi     = 8'(-90);
      max_missed   = 8'd3;
      own_id       = 8'h00;
      lost_rssi    = 8'h80;
      hop_now      = 8'h00;
      pred_len     = 0;
      results_seen = 0;
      fail_count_o = 0;
      pending_o    = 0;
      due_results.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_MIN_RSSI:   min_rssi   = cfg_data_i;
          CFG_MAX_MISSED: max_missed = cfg_data_i;
          CFG_OWN_ID:     own_id     = cfg_data_i;
          CFG_LOST_RSSI:  lost_rssi  = cfg_data_i;
          default: ;
        endcase
      end

      if (out_valid_i && !out_stall_i) begin
        if (due_results.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("result %0d: word %h with nothing expected", results_seen, out_word_i);
        end else begin
          want = due_results.pop_front();
          if (out_word_i.best_predecessor !== want.best_predecessor ||
              out_word_i.has_predecessor  !== want.has_predecessor  ||
              out_word_i.entry_count      !== want.entry_count      ||
              out_word_i.insert_dropped   !== want.insert_dropped) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display({"result %0d (expected/actual): best %h/%h has %b/%b ",
                        "count %0d/%0d dropped %b/%b"}, results_seen,
                       want.best_predecessor, out_word_i.best_predecessor,
                       want.has_predecessor, out_word_i.has_predecessor,
                       want.entry_count, out_word_i.entry_count,
                       want.insert_dropped, out_word_i.insert_dropped);
          end
        end
        results_seen++;
      end

      if (in_valid_i && !in_stall_i) due_results = {due_results, next_result(in_word_i)};
      pending_o = due_results.size();
    end
  end

endmodule

// ===== bench/predecessor_link_table_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// predecessor_link_table_unit_test: testbench for the predecessor link table
// Directed events over the table's corner cases, then phases of random event
// sequences under several register settings, with random idling on both
// channels and one long receiver hold-off. A separate checker predicts and
// compares every result word.
// ----------------------------------------------------------------------------
module predecessor_link_table_unit_test;
  import plt_pkg::*;

  localparam int LONG_HOLD = 300;      // receiver hold-off, fills the block
  localparam int LIMIT     = 500_000;  // cycles before the run is abandoned
  localparam int PHASE_LEN = 250;

  logic       clk_i     = 1'b0;
  logic       rst_ni    = 1'b0;
  logic       in_valid  = 1'b0;
  in_word_t   in_word   = '0;
  logic       out_stall = 1'b0;
  logic       cfg_we    = 1'b0;
  cfg_idx_e   cfg_idx   = CFG_MIN_RSSI;
  logic [7:0] cfg_data  = 8'h00;

  logic       in_stall;
  logic       out_valid;
  out_word_t  out_word;

  int         fail_count;
  int         pending;

  // stimulus state
  bit          idle_on      = 1'b1;    // random idling on both channels
  bit          hold_pending = 1'b0;    // asks the receiver for a long hold-off
  logic [7:0]  stim_hop     = 8'h00;   // last hop sent, keeps heard words useful
  logic [7:0]  id_base      = 8'h00;   // per-phase neighbor id pool start
  logic [7:0]  min_now      = 8'(-90); // threshold in force, for rssi biasing
  int unsigned cycles       = 0;

  always #1 clk_i = ~clk_i;

  predecessor_link_table_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  plt_result_check u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_word_i    (in_word),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_word_i   (out_word),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Run guard: a stuck handshake ends here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("predecessor_link_table_unit_test: FAIL");
      $finish;
    end
  end

  // Receiver: random bursts of stall and take; with idling off it only takes.
  // A long hold-off request wins over both and is counted out here.
  initial begin
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
    end
  end

  function automatic in_word_t make_word(op_e op, logic [7:0] id, logic [7:0] shop,
                                         logic [7:0] rssi, logic [7:0] nhop);
    in_word_t w;
    w.opcode     = op;
    w.sender_id  = id;
    w.sender_hop = shop;
    w.link_rssi  = rssi;
    w.new_hop    = nhop;
    return w;
  endfunction

  // Mostly well-formed traffic: heard words come from a small id pool at a
  // lower hop so the table fills and ages; the rest is noise. Hop changes are
  // rare, else the table never gets near full.
  function automatic in_word_t random_event();
    in_word_t    w;
    int unsigned pick;
    w.sender_id  = ($urandom_range(0, 7) == 0) ? 8'($urandom)
                                               : 8'(id_base + $urandom_range(0, 23));
    w.sender_hop = (stim_hop != 8'h00 && $urandom_range(0, 7) != 0)
                   ? 8'($urandom_range(0, stim_hop - 1)) : 8'($urandom);
    // half near the admission threshold, half anywhere
    w.link_rssi  = $urandom_range(0, 1) ? 8'($urandom)
                                        : 8'(min_now + $urandom_range(0, 6) - 3);
    pick = $urandom_range(0, 11);
    w.new_hop    = (pick < 4) ? MASTER_HOP :
                   (pick < 8) ? 8'($urandom_range(2, 6)) :
                   (pick == 8) ? 8'h00 : 8'($urandom);
    pick = $urandom_range(0, 99);
    w.opcode     = (pick < 55) ? OP_HEARD  :
                   (pick < 80) ? OP_MISSED :
                   (pick < 83) ? OP_HOP    : OP_QUERY;
    return w;
  endfunction

  // Offers one word and returns at the edge that takes it; in_valid stays up
  // so a following word goes out back to back. Stall is sampled mid-cycle.
  task automatic send_event(input in_word_t w);
    logic stalled;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    if (w.opcode == OP_HOP) stim_hop = w.new_hop;
    in_valid <= 1'b1;
    in_word  <= w;
    do begin
      @(negedge clk_i);
      stalled = in_stall;
      @(posedge clk_i);
    end while (stalled);
  endtask

  task automatic run_random(input int count);
    for (int k = 0; k < count; k++) send_event(random_event());
  endtask

  // Each result word answers one event word, so an empty prediction queue
  // means the block is idle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  // Leaves the write enable high; the caller drops it after the last write.
  task automatic write_reg(input cfg_idx_e idx, input logic [7:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
  endtask

  task automatic reconfigure(input logic [7:0] v_min, input logic [7:0] v_max,
                             input logic [7:0] v_own, input logic [7:0] v_lost);
    wait_drained();
    write_reg(CFG_MIN_RSSI, v_min);
    write_reg(CFG_MAX_MISSED, v_max);
    write_reg(CFG_OWN_ID, v_own);
    write_reg(CFG_LOST_RSSI, v_lost);
    cfg_we  <= 1'b0;
    min_now = v_min;
    id_base = 8'($urandom);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // --- directed: defaults in force (threshold -90, limit 3, own id 0) ---
    // hop 0: a heard word from the same hop is ignored, table stays empty
    send_event(make_word(OP_HEARD, 8'h11, 8'h00, 8'd20, 8'h00));
    // hop 1 loads the master; a closer node is appended, best stays master
    send_event(make_word(OP_HOP, 8'h00, 8'h00, 8'h00, MASTER_HOP));
    send_event(make_word(OP_HEARD, 8'hFF, 8'h00, 8'h7F, 8'h00));
    // far hop clears the table; empty table answers with the own id
    send_event(make_word(OP_HOP, 8'h00, 8'h00, 8'h00, 8'hFF));
    // one below threshold is refused, a missed round for a stranger ignored
    send_event(make_word(OP_HEARD, 8'h80, 8'hFE, 8'(-91), 8'h00));
    send_event(make_word(OP_MISSED, 8'h42, 8'h00, 8'h00, 8'h00));
    // fill all sixteen slots; ties at the top rssi keep the first one
    for (int k = 1; k <= TABLE_DEPTH; k++)
      send_event(make_word(OP_HEARD, 8'(k), 8'hFE,
                           (k % 4 == 0) ? 8'h7F : 8'(-90 + k), 8'h00));
    // refresh of a known node ignores the threshold
    send_event(make_word(OP_HEARD, 8'd8, 8'h00, 8'h80, 8'h00));
    // full table: admissible newcomer is dropped and flagged
    send_event(make_word(OP_HEARD, 8'hC8, 8'h00, 8'h7F, 8'h00));
    // three missed rounds drop a middle entry, the rest shift up
    repeat (3) send_event(make_word(OP_MISSED, 8'd5, 8'h00, 8'h00, 8'h00));

    // --- random phases, one register setting each ---
    reconfigure(8'(-90), 8'd3, 8'h00, 8'h80);
    run_random(PHASE_LEN);

    // loosest threshold, removal on the first miss; long hold-off midway
    reconfigure(8'h80, 8'd1, 8'hFF, 8'h7F);
    run_random(PHASE_LEN / 2);
    hold_pending = 1'b1;
    run_random(PHASE_LEN / 2);

    // strictest threshold, slowest aging
    reconfigure(8'h7F, 8'hFF, 8'h00, 8'h80);
    run_random(PHASE_LEN);

    // zero limit: any miss removes
    reconfigure(8'h00, 8'h00, 8'($urandom), 8'($urandom));
    run_random(PHASE_LEN);

    reconfigure(8'(-int'($urandom_range(20, 100))), 8'($urandom_range(2, 8)),
                8'($urandom), 8'($urandom));
    run_random(PHASE_LEN);

    // closing stretch at full rate
    idle_on = 1'b0;
    reconfigure(8'(-60), 8'd4, 8'hA5, 8'(-100));
    run_random(PHASE_LEN);

    wait_drained();
    repeat (2 * TABLE_DEPTH + 8) @(posedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("predecessor_link_table_unit_test: PASS");
    else
      $display("predecessor_link_table_unit_test: FAIL");
    $finish;
  end

endmodule
